// File: src/twbt_pkg.sv
// Shared types and constants for the touch wake and backlight timeout block.
package twbt_pkg;

	localparam int RAW_W   = 12;
	localparam int COORD_W = 22;
	localparam int IDLE_W  = 22;
	localparam int IDX_W   = 3;

	localparam logic [IDX_W-1:0] REG_X_MIN   = 3'd0;
	localparam logic [IDX_W-1:0] REG_X_MAX   = 3'd1;
	localparam logic [IDX_W-1:0] REG_Y_MIN   = 3'd2;
	localparam logic [IDX_W-1:0] REG_Y_MAX   = 3'd3;
	localparam logic [IDX_W-1:0] REG_TIMEOUT = 3'd4;

	localparam logic [RAW_W-1:0] X_MIN_RST   = 12'd21;
	localparam logic [RAW_W-1:0] X_MAX_RST   = 12'd295;
	localparam logic [RAW_W-1:0] Y_MIN_RST   = 12'd20;
	localparam logic [RAW_W-1:0] Y_MAX_RST   = 12'd219;
	localparam logic [RAW_W-1:0] TIMEOUT_RST = 12'd30;

	localparam logic [IDLE_W-1:0] IDLE_MAX  = 22'h3FFFFF;
	localparam logic [IDLE_W-1:0] MS_PER_S  = 22'd1000;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_AXIS,
		ST_DONE
	} twbt_state_t;

	typedef enum logic [1:0] {
		AX_IDLE,
		AX_MUL,
		AX_DIV,
		AX_FIN
	} twbt_axis_state_t;

endpackage

// File: src/twbt_if.sv
// Input and output channel interfaces of the touch wake and backlight timeout block.
interface twbt_in_if;
	logic                         valid;
	logic                         ready;
	logic                         action;
	logic [twbt_pkg::RAW_W-1:0]   raw_x;
	logic [twbt_pkg::RAW_W-1:0]   raw_y;
	logic [twbt_pkg::RAW_W-1:0]   pressure;

	modport source(output valid, action, raw_x, raw_y, pressure, input ready);
	modport sink(input valid, action, raw_x, raw_y, pressure, output ready);
endinterface

interface twbt_out_if;
	logic                                valid;
	logic                                ready;
	logic                                touch_pressed;
	logic signed [twbt_pkg::COORD_W-1:0] screen_x;
	logic signed [twbt_pkg::COORD_W-1:0] screen_y;
	logic                                backlight_on;
	logic                                woke_now;
	logic                                timed_out_now;

	modport source(output valid, touch_pressed, screen_x, screen_y, backlight_on, woke_now,
		timed_out_now, input ready);
	modport sink(input valid, touch_pressed, screen_x, screen_y, backlight_on, woke_now,
		timed_out_now, output ready);
endinterface

// File: src/twbt_axis.sv
// One axis of the touch map: bit-serial multiply and restoring divide, then offset and clamp.
module twbt_axis #(
	parameter int TOP = 320
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [twbt_pkg::RAW_W-1:0]          v,
	input  logic [twbt_pkg::RAW_W-1:0]          lo,
	input  logic [twbt_pkg::RAW_W-1:0]          hi,
	output logic                                done,
	output logic signed [twbt_pkg::COORD_W-1:0] res
);

	localparam int RW = $clog2(TOP);
	localparam int PW = twbt_pkg::RAW_W + RW;
	localparam int SW = (PW + 2 > twbt_pkg::COORD_W + 1) ? PW + 2 : twbt_pkg::COORD_W + 1;
	localparam int CW = $clog2(PW);
	localparam int RAW_W = twbt_pkg::RAW_W;
	localparam logic [PW-1:0]        RMAG   = PW'(TOP - 1);
	localparam logic signed [SW-1:0] TOP_S  = SW'(TOP);
	localparam logic signed [SW-1:0] SAT_HI = SW'((2 ** (twbt_pkg::COORD_W - 1)) - 1);
	localparam logic signed [SW-1:0] SAT_LO = SW'(-(2 ** (twbt_pkg::COORD_W - 1)));

	twbt_pkg::twbt_axis_state_t state_q, state_d;

	logic [CW-1:0]    cnt_q;
	logic [RAW_W-1:0] mplier_q;
	logic [PW-1:0]    mcand_q;
	logic [PW-1:0]    n_q;
	logic [RAW_W-1:0] rem_q;
	logic [RAW_W-1:0] m_q;
	logic             neg_q;
	logic             zero_q;
	logic             done_q;
	logic signed [twbt_pkg::COORD_W-1:0] res_q;

	logic load_en, mul_en, div_en, fin_en;

	logic signed [RAW_W:0] diff, run;
	logic [RAW_W-1:0]      dmag, rmag;
	logic [PW-1:0]         mul_sum;
	logic [RAW_W:0]        shifted;
	logic [RAW_W+1:0]      trial;
	logic                  ge;
	logic signed [SW-1:0]  sq, sum;

	assign diff = $signed({1'b0, v}) - $signed({1'b0, lo});
	assign run  = $signed({1'b0, hi}) - $signed({1'b0, lo});
	assign dmag = diff[RAW_W] ? RAW_W'(-diff) : diff[RAW_W-1:0];
	assign rmag = run[RAW_W] ? RAW_W'(-run) : run[RAW_W-1:0];

	assign mul_sum = n_q + (mplier_q[0] ? mcand_q : '0);

	assign shifted = {rem_q, n_q[PW-1]};
	assign trial   = {1'b0, shifted} - {2'b00, m_q};
	assign ge      = ~trial[RAW_W+1];

	assign sq  = $signed({{(SW-PW){1'b0}}, n_q});
	assign sum = (neg_q ? -sq : sq) + TOP_S;

	always_comb begin
		state_d = state_q;
		case (state_q)
			twbt_pkg::AX_IDLE: if (start) state_d = twbt_pkg::AX_MUL;
			twbt_pkg::AX_MUL:  if (cnt_q == '0) state_d = twbt_pkg::AX_DIV;
			twbt_pkg::AX_DIV:  if (cnt_q == '0) state_d = twbt_pkg::AX_FIN;
			twbt_pkg::AX_FIN:  state_d = twbt_pkg::AX_IDLE;
			default:           state_d = twbt_pkg::AX_IDLE;
		endcase
	end

	always_comb begin
		load_en = 1'b0;
		mul_en  = 1'b0;
		div_en  = 1'b0;
		fin_en  = 1'b0;
		case (state_q)
			twbt_pkg::AX_IDLE: load_en = start;
			twbt_pkg::AX_MUL:  mul_en  = 1'b1;
			twbt_pkg::AX_DIV:  div_en  = 1'b1;
			twbt_pkg::AX_FIN:  fin_en  = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= twbt_pkg::AX_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_en) begin
				cnt_q  <= CW'(RAW_W - 1);
				done_q <= 1'b0;
			end else if (mul_en) begin
				cnt_q <= (cnt_q == '0) ? CW'(PW - 1) : cnt_q - 1'b1;
			end else if (div_en) begin
				cnt_q <= cnt_q - 1'b1;
			end else if (fin_en) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_en) begin
			mplier_q <= dmag;
			mcand_q  <= RMAG;
			n_q      <= '0;
			rem_q    <= '0;
			m_q      <= rmag;
			neg_q    <= ~diff[RAW_W] ^ run[RAW_W];
			zero_q   <= (run == '0);
		end else if (mul_en) begin
			n_q      <= mul_sum;
			mcand_q  <= {mcand_q[PW-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[RAW_W-1:1]};
		end else if (div_en) begin
			rem_q <= ge ? trial[RAW_W-1:0] : shifted[RAW_W-1:0];
			n_q   <= {n_q[PW-2:0], ge};
		end else if (fin_en) begin
			if (zero_q)
				res_q <= '1;
			else if (sum > SAT_HI)
				res_q <= SAT_HI[twbt_pkg::COORD_W-1:0];
			else if (sum < SAT_LO)
				res_q <= SAT_LO[twbt_pkg::COORD_W-1:0];
			else
				res_q <= sum[twbt_pkg::COORD_W-1:0];
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// File: src/touch_wake_and_backlight_timeout_top.sv
// Top level of the touch wake and backlight timeout block.
// Each transaction is a millisecond tick or a raw touch sample and yields one result.
// A tick, a release or a press that is ignored goes from evaluation straight to a loaded
// result. A reported press also runs both axes side by side: each axis runs a bit-serial
// 12-step multiply and a restoring divide of 12 + clog2(SCREEN_WIDTH or SCREEN_HEIGHT,
// its own size) steps. One transaction is in work at a time; the result register lets
// the next one in while a result waits.
module touch_wake_and_backlight_timeout_top #(
	parameter int SCREEN_WIDTH  = 320,
	parameter int SCREEN_HEIGHT = 240
) (
	input  logic                         clk,
	input  logic                         arst_n,
	twbt_in_if.sink                      in_ch,
	twbt_out_if.source                   out_ch,
	input  logic                         cfg_we,
	input  logic [twbt_pkg::IDX_W-1:0]   cfg_index,
	input  logic [twbt_pkg::RAW_W-1:0]   cfg_data
);

	localparam int RAW_W = twbt_pkg::RAW_W;

	twbt_pkg::twbt_state_t state_q, state_d;

	logic [RAW_W-1:0] x_min_q, x_max_q, y_min_q, y_max_q, timeout_q;
	logic [twbt_pkg::IDLE_W-1:0] idle_ms_q;
	logic screen_on_q, ignore_q;

	logic             act_q;
	logic [RAW_W-1:0] rx_q, ry_q, pr_q;
	logic             pressed_q, woke_q, timed_q;

	logic out_valid_q;
	logic out_pressed_q, out_backlight_q, out_woke_q, out_timed_q;
	logic signed [twbt_pkg::COORD_W-1:0] out_x_q, out_y_q;

	logic in_ready, accept, eval_en, axis_start, out_load;
	logic press_ok;
	logic x_done, y_done;
	logic signed [twbt_pkg::COORD_W-1:0] x_res, y_res;
	logic [twbt_pkg::IDLE_W-1:0] thresh, idle_inc;

	assign thresh   = twbt_pkg::IDLE_W'(timeout_q) * twbt_pkg::MS_PER_S;
	assign idle_inc = (idle_ms_q == twbt_pkg::IDLE_MAX) ? idle_ms_q : idle_ms_q + 1'b1;
	assign press_ok = act_q && (pr_q != '0) && screen_on_q && !ignore_q;
	assign accept   = in_ch.valid && in_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			twbt_pkg::ST_IDLE: if (accept) state_d = twbt_pkg::ST_EVAL;
			twbt_pkg::ST_EVAL: state_d = press_ok ? twbt_pkg::ST_AXIS : twbt_pkg::ST_DONE;
			twbt_pkg::ST_AXIS: if (x_done && y_done) state_d = twbt_pkg::ST_DONE;
			twbt_pkg::ST_DONE: if (!out_valid_q || out_ch.ready) state_d = twbt_pkg::ST_IDLE;
			default:           state_d = twbt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		eval_en    = 1'b0;
		axis_start = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			twbt_pkg::ST_IDLE: in_ready = 1'b1;
			twbt_pkg::ST_EVAL: begin
				eval_en    = 1'b1;
				axis_start = press_ok;
			end
			twbt_pkg::ST_DONE: out_load = !out_valid_q || out_ch.ready;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= twbt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q   <= twbt_pkg::X_MIN_RST;
			x_max_q   <= twbt_pkg::X_MAX_RST;
			y_min_q   <= twbt_pkg::Y_MIN_RST;
			y_max_q   <= twbt_pkg::Y_MAX_RST;
			timeout_q <= twbt_pkg::TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				twbt_pkg::REG_X_MIN:   x_min_q   <= cfg_data;
				twbt_pkg::REG_X_MAX:   x_max_q   <= cfg_data;
				twbt_pkg::REG_Y_MIN:   y_min_q   <= cfg_data;
				twbt_pkg::REG_Y_MAX:   y_max_q   <= cfg_data;
				twbt_pkg::REG_TIMEOUT: timeout_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// idle timer, screen and wake state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_ms_q   <= '0;
			screen_on_q <= 1'b1;
			ignore_q    <= 1'b0;
		end else if (eval_en) begin
			if (!act_q) begin
				idle_ms_q <= idle_inc;
				if (screen_on_q && (idle_inc > thresh))
					screen_on_q <= 1'b0;
			end else if (pr_q != '0) begin
				idle_ms_q <= '0;
				if (!screen_on_q) begin
					screen_on_q <= 1'b1;
					ignore_q    <= 1'b1;
				end
			end else begin
				ignore_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= in_ch.action;
			rx_q  <= in_ch.raw_x;
			ry_q  <= in_ch.raw_y;
			pr_q  <= in_ch.pressure;
		end
		if (eval_en) begin
			pressed_q <= press_ok;
			woke_q    <= act_q && (pr_q != '0) && !screen_on_q;
			timed_q   <= !act_q && screen_on_q && (idle_inc > thresh);
		end
	end

	twbt_axis #(
		.TOP(SCREEN_WIDTH)
	) u_axis_x (
		.clk   (clk),
		.arst_n(arst_n),
		.start (axis_start),
		.v     (rx_q),
		.lo    (x_min_q),
		.hi    (x_max_q),
		.done  (x_done),
		.res   (x_res)
	);

	twbt_axis #(
		.TOP(SCREEN_HEIGHT)
	) u_axis_y (
		.clk   (clk),
		.arst_n(arst_n),
		.start (axis_start),
		.v     (ry_q),
		.lo    (y_min_q),
		.hi    (y_max_q),
		.done  (y_done),
		.res   (y_res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_pressed_q   <= pressed_q;
			out_x_q         <= pressed_q ? x_res : '0;
			out_y_q         <= pressed_q ? y_res : '0;
			out_backlight_q <= screen_on_q;
			out_woke_q      <= woke_q;
			out_timed_q     <= timed_q;
		end
	end

	assign in_ch.ready          = in_ready;
	assign out_ch.valid         = out_valid_q;
	assign out_ch.touch_pressed = out_pressed_q;
	assign out_ch.screen_x      = out_x_q;
	assign out_ch.screen_y      = out_y_q;
	assign out_ch.backlight_on  = out_backlight_q;
	assign out_ch.woke_now      = out_woke_q;
	assign out_ch.timed_out_now = out_timed_q;

endmodule
